@@ rtl/core/pafp_pkg.sv @@
// Shared types, widths and constants of the pointing angle pipeline.
// Has no dependencies; every other file takes names from here by scope.
package pafp_pkg;

	localparam int COORD_W = 24;
	localparam int DIFF_W = 25;
	localparam int SQ_W = 50;
	localparam int HSQ_W = 51;
	localparam int SSQ_W = 52;
	localparam int RAD_W = 64;
	localparam int ROOT_W = 32;
	localparam int REM_W = 35;
	localparam int CW = 60;
	localparam int ZW = 36;
	localparam int ANG_FRAC = 24;
	localparam int YAW_SCALE_SH = 30;
	localparam int PITCH_SCALE_SH = 23;
	localparam int HORIZ_EXTRA_SH = 14;
	localparam int YAW_W = 17;
	localparam int PITCH_W = 16;
	localparam int SPAN_W = 25;

	localparam int CORDIC_STEPS_DEF = 20;
	localparam int FRAC_BITS_DEF = 8;

	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [CW-1:0] cw_t;
	typedef logic signed [ZW-1:0] z_t;
	typedef logic [2:0] yfix_t;

	// degrees with 24 fraction bits
	localparam z_t DEG90 = 36'sd1509949440;
	localparam z_t DEG180 = 36'sd3019898880;

	// yaw source: CORDIC result or one of the exact axis angles
	localparam yfix_t YA_CORDIC = 3'd0;
	localparam yfix_t YA_ZERO = 3'd1;
	localparam yfix_t YA_180 = 3'd2;
	localparam yfix_t YA_P90 = 3'd3;
	localparam yfix_t YA_N90 = 3'd4;

	typedef struct packed {
		diff_t dx;
		diff_t dy;
		diff_t dz;
		logic degen;
		logic hsq_zero;
	} geo_t;

	typedef struct packed {
		logic [SPAN_W-1:0] span;
		logic degen;
		logic hsq_zero;
		logic dz_zero;
		logic dz_neg;
		yfix_t yfix;
	} tail_t;

	// atan(2^-i) in degrees, 24 fraction bits
	function automatic z_t atan_deg(input int unsigned i);
		z_t r;
		case (i)
			0: r = 36'sd754974720;
			1: r = 36'sd445687602;
			2: r = 36'sd235489088;
			3: r = 36'sd119537938;
			4: r = 36'sd60000934;
			5: r = 36'sd30029717;
			6: r = 36'sd15018523;
			7: r = 36'sd7509720;
			8: r = 36'sd3754917;
			9: r = 36'sd1877466;
			10: r = 36'sd938734;
			11: r = 36'sd469367;
			12: r = 36'sd234684;
			13: r = 36'sd117342;
			14: r = 36'sd58671;
			15: r = 36'sd29335;
			16: r = 36'sd14668;
			17: r = 36'sd7334;
			18: r = 36'sd3667;
			19: r = 36'sd1833;
			20: r = 36'sd917;
			21: r = 36'sd458;
			22: r = 36'sd229;
			23: r = 36'sd115;
			24: r = 36'sd57;
			25: r = 36'sd29;
			26: r = 36'sd14;
			27: r = 36'sd7;
			28: r = 36'sd4;
			29: r = 36'sd2;
			30: r = 36'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/pointing_angles_from_two_points.sv @@
// Top level: yaw, pitch and distance between two points, fully pipelined.
// Depends on pafp_pkg, pafp_front, pafp_sqrt and pafp_cordic.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | src_x src_y src_z dst_x dst_y dst_z
//  out     | out_valid / out_stall| yaw_deg pitch_deg span degenerate
//
// One item enters per cycle while in_stall is low, passing through three
// front stages, 32 square-root stages (one root bit each), one set-up stage,
// one stage per CORDIC step, and the output register.
// Reset clears only the valid bits; payload registers are left as they are.
// The pipeline moves as one; a skid register behind the output register
// catches the item in flight when out_stall rises, and in_stall is just that
// skid register being full, so in_stall comes straight from a flop.
module pointing_angles_from_two_points #(
	parameter int CORDIC_STEPS = pafp_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [pafp_pkg::COORD_W-1:0]   src_x,
	input  logic signed [pafp_pkg::COORD_W-1:0]   src_y,
	input  logic signed [pafp_pkg::COORD_W-1:0]   src_z,
	input  logic signed [pafp_pkg::COORD_W-1:0]   dst_x,
	input  logic signed [pafp_pkg::COORD_W-1:0]   dst_y,
	input  logic signed [pafp_pkg::COORD_W-1:0]   dst_z,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [pafp_pkg::YAW_W-1:0]            yaw_deg,
	output logic signed [pafp_pkg::PITCH_W-1:0]   pitch_deg,
	output logic [pafp_pkg::SPAN_W-1:0]           span,
	output logic                                  degenerate
);

	// output fraction is tied to the output port widths
	localparam int FRAC_BITS = pafp_pkg::FRAC_BITS_DEF;

	// shift from internal angle fraction down to the output fraction
	localparam int SH = pafp_pkg::ANG_FRAC - FRAC_BITS;
	localparam pafp_pkg::z_t RND = pafp_pkg::z_t'(1) <<< (SH - 1);
	localparam pafp_pkg::z_t FULL = pafp_pkg::z_t'(360) <<< FRAC_BITS;
	localparam pafp_pkg::z_t LIM = pafp_pkg::z_t'(90) <<< FRAC_BITS;

	typedef struct packed {
		logic [pafp_pkg::YAW_W-1:0]          yaw;
		logic signed [pafp_pkg::PITCH_W-1:0] pitch;
		logic [pafp_pkg::SPAN_W-1:0]         span;
		logic                                degen;
	} res_t;

	logic pipe_en;

	logic front_valid;
	pafp_pkg::geo_t front_geo;
	logic [pafp_pkg::SSQ_W-1:0] front_ssq;
	logic [pafp_pkg::HSQ_W-1:0] front_hsq;

	logic sqrt_valid;
	pafp_pkg::geo_t sqrt_geo;
	logic [pafp_pkg::ROOT_W-1:0] sqrt_span_root, sqrt_h_root;
	logic [pafp_pkg::REM_W-1:0] sqrt_span_rem;

	logic pipe_valid;
	pafp_pkg::tail_t pipe_tail;
	pafp_pkg::z_t z_yaw, z_pitch;

	pafp_pkg::z_t yaw_a, yaw_r, pitch_r;
	res_t res_pipe;

	res_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;

	// the whole pipeline holds while the skid register is occupied
	assign pipe_en = !skid_valid_q;
	assign in_stall = skid_valid_q;

	pafp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (in_valid),
		.src_x     (src_x),
		.src_y     (src_y),
		.src_z     (src_z),
		.dst_x     (dst_x),
		.dst_y     (dst_y),
		.dst_z     (dst_z),
		.out_valid (front_valid),
		.geo       (front_geo),
		.ssq       (front_ssq),
		.hsq       (front_hsq)
	);

	pafp_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (front_valid),
		.geo       (front_geo),
		.ssq       (front_ssq),
		.hsq       (front_hsq),
		.out_valid (sqrt_valid),
		.out_geo   (sqrt_geo),
		.span_root (sqrt_span_root),
		.span_rem  (sqrt_span_rem),
		.h_root    (sqrt_h_root)
	);

	pafp_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (sqrt_valid),
		.geo       (sqrt_geo),
		.span_root (sqrt_span_root),
		.span_rem  (sqrt_span_rem),
		.h_root    (sqrt_h_root),
		.out_valid (pipe_valid),
		.tail      (pipe_tail),
		.z_yaw     (z_yaw),
		.z_pitch   (z_pitch)
	);

	// Final rounding. Yaw is 180 minus the bearing, rounded, then wrapped
	// into one turn; axis-aligned directions take their exact bearing.
	always_comb begin
		unique case (pipe_tail.yfix)
			pafp_pkg::YA_CORDIC: yaw_a = z_yaw;
			pafp_pkg::YA_ZERO:   yaw_a = '0;
			pafp_pkg::YA_180:    yaw_a = pafp_pkg::DEG180;
			pafp_pkg::YA_P90:    yaw_a = pafp_pkg::DEG90;
			pafp_pkg::YA_N90:    yaw_a = -pafp_pkg::DEG90;
			default:             yaw_a = '0;
		endcase
		yaw_r = (pafp_pkg::DEG180 - yaw_a + RND) >>> SH;
		if (yaw_r >= FULL) begin
			yaw_r = yaw_r - FULL;
		end
		if (yaw_r < 0) begin
			yaw_r = yaw_r + FULL;
		end

		// pitch: zero for a flat or empty difference, a right angle straight
		// up or down, otherwise the rounded CORDIC angle held to +/-90
		pitch_r = (z_pitch + RND) >>> SH;
		if (pipe_tail.dz_zero) begin
			pitch_r = '0;
		end else if (pipe_tail.hsq_zero) begin
			pitch_r = pipe_tail.dz_neg ? -LIM : LIM;
		end else if (pitch_r > LIM) begin
			pitch_r = LIM;
		end else if (pitch_r < -LIM) begin
			pitch_r = -LIM;
		end

		res_pipe.yaw = pafp_pkg::YAW_W'(yaw_r);
		res_pipe.pitch = pafp_pkg::PITCH_W'(pitch_r);
		res_pipe.span = pipe_tail.span;
		res_pipe.degen = pipe_tail.degen;
	end

	// Output register with skid: when the output is free, take the skid item
	// first, else the pipeline item; when the output holds, park the item
	// leaving the pipeline in the skid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= skid_valid_q || pipe_valid;
			skid_valid_q <= 1'b0;
		end else if (pipe_valid && pipe_en) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			out_q <= skid_valid_q ? skid_q : res_pipe;
		end else if (pipe_en) begin
			skid_q <= res_pipe;
		end
	end

	assign out_valid = out_valid_q;
	assign yaw_deg = out_q.yaw;
	assign pitch_deg = out_q.pitch;
	assign span = out_q.span;
	assign degenerate = out_q.degen;

endmodule

@@ rtl/core/pafp_front.sv @@
// Front stages: coordinate differences, squares and squared distances.
// Depends on pafp_pkg.
module pafp_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  logic signed [pafp_pkg::COORD_W-1:0]   src_x,
	input  logic signed [pafp_pkg::COORD_W-1:0]   src_y,
	input  logic signed [pafp_pkg::COORD_W-1:0]   src_z,
	input  logic signed [pafp_pkg::COORD_W-1:0]   dst_x,
	input  logic signed [pafp_pkg::COORD_W-1:0]   dst_y,
	input  logic signed [pafp_pkg::COORD_W-1:0]   dst_z,
	output logic                                  out_valid,
	output pafp_pkg::geo_t                        geo,
	output logic [pafp_pkg::SSQ_W-1:0]            ssq,
	output logic [pafp_pkg::HSQ_W-1:0]            hsq
);

	logic valid_s1, valid_s2, valid_s3;
	pafp_pkg::diff_t dx_s1, dy_s1, dz_s1, dx_s2, dy_s2, dz_s2;
	logic signed [pafp_pkg::SQ_W-1:0] px, py, pz;
	logic [pafp_pkg::SQ_W-1:0] sqx_s2, sqy_s2, sqz_s2;
	logic [pafp_pkg::HSQ_W-1:0] hsq_sum;
	pafp_pkg::geo_t geo_s3;
	logic [pafp_pkg::SSQ_W-1:0] ssq_s3;
	logic [pafp_pkg::HSQ_W-1:0] hsq_s3;

	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;
	assign pz = dz_s1 * dz_s1;
	assign hsq_sum = pafp_pkg::HSQ_W'(sqx_s2) + pafp_pkg::HSQ_W'(sqy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= pafp_pkg::diff_t'(dst_x) - pafp_pkg::diff_t'(src_x);
			dy_s1 <= pafp_pkg::diff_t'(dst_y) - pafp_pkg::diff_t'(src_y);
			dz_s1 <= pafp_pkg::diff_t'(dst_z) - pafp_pkg::diff_t'(src_z);
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
			dz_s2 <= dz_s1;
			sqx_s2 <= px;
			sqy_s2 <= py;
			sqz_s2 <= pz;
			hsq_s3 <= hsq_sum;
			ssq_s3 <= pafp_pkg::SSQ_W'(hsq_sum) + pafp_pkg::SSQ_W'(sqz_s2);
			geo_s3.dx <= dx_s2;
			geo_s3.dy <= dy_s2;
			geo_s3.dz <= dz_s2;
			geo_s3.hsq_zero <= (dx_s2 == '0) && (dy_s2 == '0);
			geo_s3.degen <= (dx_s2 == '0) && (dy_s2 == '0) && (dz_s2 == '0);
		end
	end

	assign out_valid = valid_s3;
	assign geo = geo_s3;
	assign ssq = ssq_s3;
	assign hsq = hsq_s3;

endmodule

@@ rtl/core/pafp_sqrt.sv @@
// Pipelined restoring square roots, one result bit per stage, two lanes:
// full distance (with remainder) and horizontal distance. Depends on pafp_pkg.
module pafp_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  pafp_pkg::geo_t                    geo,
	input  logic [pafp_pkg::SSQ_W-1:0]        ssq,
	input  logic [pafp_pkg::HSQ_W-1:0]        hsq,
	output logic                              out_valid,
	output pafp_pkg::geo_t                    out_geo,
	output logic [pafp_pkg::ROOT_W-1:0]       span_root,
	output logic [pafp_pkg::REM_W-1:0]        span_rem,
	output logic [pafp_pkg::ROOT_W-1:0]       h_root
);

	localparam int N = pafp_pkg::ROOT_W;

	typedef struct packed {
		logic [pafp_pkg::RAD_W-1:0]  n;
		logic [pafp_pkg::REM_W-1:0]  rem;
		logic [pafp_pkg::ROOT_W-1:0] root;
	} sq_t;

	function automatic sq_t sq_step(input sq_t a);
		logic [pafp_pkg::REM_W-1:0] rt;
		logic [pafp_pkg::REM_W-1:0] tr;
		sq_t r;
		rt = {a.rem[pafp_pkg::REM_W-3:0], a.n[pafp_pkg::RAD_W-1 -: 2]};
		tr = pafp_pkg::REM_W'({a.root, 2'b01});
		r.n = a.n << 2;
		if (rt >= tr) begin
			r.rem = rt - tr;
			r.root = {a.root[pafp_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			r.rem = rt;
			r.root = {a.root[pafp_pkg::ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	sq_t span_in [N];
	sq_t h_in [N];
	pafp_pkg::geo_t geo_in [N];
	logic valid_in [N];
	sq_t span_s [N];
	sq_t h_s [N];
	pafp_pkg::geo_t geo_s [N];
	logic valid_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		if (k == 0) begin : g_first
			assign span_in[k] = '{n: pafp_pkg::RAD_W'(ssq), rem: '0, root: '0};
			assign h_in[k] = '{n: pafp_pkg::RAD_W'(hsq) << pafp_pkg::HORIZ_EXTRA_SH,
				rem: '0, root: '0};
			assign geo_in[k] = geo;
			assign valid_in[k] = in_valid;
		end else begin : g_next
			assign span_in[k] = span_s[k-1];
			assign h_in[k] = h_s[k-1];
			assign geo_in[k] = geo_s[k-1];
			assign valid_in[k] = valid_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_in[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				span_s[k] <= sq_step(span_in[k]);
				h_s[k] <= sq_step(h_in[k]);
				geo_s[k] <= geo_in[k];
			end
		end
	end

	assign out_valid = valid_s[N-1];
	assign out_geo = geo_s[N-1];
	assign span_root = span_s[N-1].root;
	assign span_rem = span_s[N-1].rem;
	assign h_root = h_s[N-1].root;

endmodule

@@ rtl/core/pafp_cordic.sv @@
// Quadrant set-up and pipelined CORDIC vectoring for yaw and pitch lanes.
// Depends on pafp_pkg.
module pafp_cordic #(
	parameter int CORDIC_STEPS = pafp_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  pafp_pkg::geo_t                    geo,
	input  logic [pafp_pkg::ROOT_W-1:0]       span_root,
	input  logic [pafp_pkg::REM_W-1:0]        span_rem,
	input  logic [pafp_pkg::ROOT_W-1:0]       h_root,
	output logic                              out_valid,
	output pafp_pkg::tail_t                   tail,
	output pafp_pkg::z_t                      z_yaw,
	output pafp_pkg::z_t                      z_pitch
);

	typedef struct packed {
		pafp_pkg::cw_t x;
		pafp_pkg::cw_t y;
		pafp_pkg::z_t  z;
	} lane_t;

	function automatic lane_t rot_step(input lane_t a, input int unsigned i);
		pafp_pkg::cw_t xs;
		pafp_pkg::cw_t ys;
		lane_t r;
		xs = a.x >>> i;
		ys = a.y >>> i;
		if (!a.y[pafp_pkg::CW-1]) begin
			r.x = a.x + ys;
			r.y = a.y - xs;
			r.z = a.z + pafp_pkg::atan_deg(i);
		end else begin
			r.x = a.x - ys;
			r.y = a.y + xs;
			r.z = a.z - pafp_pkg::atan_deg(i);
		end
		return r;
	endfunction

	pafp_pkg::cw_t num_w, den_w;
	lane_t yaw_init, pitch_init;
	pafp_pkg::tail_t tail_init;
	logic [pafp_pkg::REM_W-1:0] root_ext;

	lane_t yaw_s0, pitch_s0;
	pafp_pkg::tail_t tail_s0;
	logic valid_s0;

	assign num_w = pafp_pkg::cw_t'(geo.dx) <<< pafp_pkg::YAW_SCALE_SH;
	assign den_w = pafp_pkg::cw_t'(geo.dy) <<< pafp_pkg::YAW_SCALE_SH;
	assign root_ext = pafp_pkg::REM_W'(span_root);

	always_comb begin
		// fold the left half-plane onto the right one
		if (geo.dy[pafp_pkg::DIFF_W-1]) begin
			if (!geo.dx[pafp_pkg::DIFF_W-1]) begin
				yaw_init = '{x: num_w, y: -den_w, z: pafp_pkg::DEG90};
			end else begin
				yaw_init = '{x: -num_w, y: den_w, z: -pafp_pkg::DEG90};
			end
		end else begin
			yaw_init = '{x: den_w, y: num_w, z: '0};
		end
		pitch_init.x = pafp_pkg::cw_t'(h_root) <<< pafp_pkg::PITCH_SCALE_SH;
		pitch_init.y = pafp_pkg::cw_t'(geo.dz) <<< pafp_pkg::YAW_SCALE_SH;
		pitch_init.z = '0;

		tail_init.span = pafp_pkg::SPAN_W'(span_root +
			pafp_pkg::ROOT_W'(span_rem > root_ext));
		tail_init.degen = geo.degen;
		tail_init.hsq_zero = geo.hsq_zero;
		tail_init.dz_zero = (geo.dz == '0);
		tail_init.dz_neg = geo.dz[pafp_pkg::DIFF_W-1];
		// exact angles on the axes
		if (geo.hsq_zero) begin
			tail_init.yfix = pafp_pkg::YA_ZERO;
		end else if (geo.dx == '0) begin
			tail_init.yfix = geo.dy[pafp_pkg::DIFF_W-1] ? pafp_pkg::YA_180 : pafp_pkg::YA_ZERO;
		end else if (geo.dy == '0) begin
			tail_init.yfix = geo.dx[pafp_pkg::DIFF_W-1] ? pafp_pkg::YA_N90 : pafp_pkg::YA_P90;
		end else begin
			tail_init.yfix = pafp_pkg::YA_CORDIC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (en) begin
			valid_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_s0 <= yaw_init;
			pitch_s0 <= pitch_init;
			tail_s0 <= tail_init;
		end
	end

	lane_t yaw_in [CORDIC_STEPS];
	lane_t pitch_in [CORDIC_STEPS];
	pafp_pkg::tail_t tail_in [CORDIC_STEPS];
	logic valid_in [CORDIC_STEPS];
	lane_t yaw_s [CORDIC_STEPS];
	lane_t pitch_s [CORDIC_STEPS];
	pafp_pkg::tail_t tail_s [CORDIC_STEPS];
	logic valid_s [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		if (i == 0) begin : g_first
			assign yaw_in[i] = yaw_s0;
			assign pitch_in[i] = pitch_s0;
			assign tail_in[i] = tail_s0;
			assign valid_in[i] = valid_s0;
		end else begin : g_next
			assign yaw_in[i] = yaw_s[i-1];
			assign pitch_in[i] = pitch_s[i-1];
			assign tail_in[i] = tail_s[i-1];
			assign valid_in[i] = valid_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en) begin
				valid_s[i] <= valid_in[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				yaw_s[i] <= rot_step(yaw_in[i], i);
				pitch_s[i] <= rot_step(pitch_in[i], i);
				tail_s[i] <= tail_in[i];
			end
		end
	end

	assign out_valid = valid_s[CORDIC_STEPS-1];
	assign tail = tail_s[CORDIC_STEPS-1];
	assign z_yaw = yaw_s[CORDIC_STEPS-1].z;
	assign z_pitch = pitch_s[CORDIC_STEPS-1].z;

endmodule
